### rtl/spm_pkg.sv
// Shared types and constants for the sparse polynomial multiplier.
package spm_pkg;

    localparam int unsigned MAX_TERMS_DEF = 8;
    localparam int unsigned TERM_W        = 16;
    localparam int unsigned COEF_W        = 38;
    localparam int unsigned EXP_W         = 17;

    typedef struct packed {
        logic              v;
        logic [COEF_W-1:0] coef;
        logic [EXP_W-1:0]  expo;
    } cell_t;

    typedef struct packed {
        logic              ins;
        logic              shift;
        logic [COEF_W-1:0] coef;
        logic [EXP_W-1:0]  expo;
    } cmd_t;

    typedef struct packed {
        logic any_eq;
        logic cancel;
    } glob_t;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_MULT  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

### rtl/sparse_polynomial_multiply.sv
// Top level of the sparse polynomial multiplier.
//
// Input channel s_*: one term per transfer. s_operation picks the first (0)
// or second (1) polynomial, s_final_term closes it. Terms for a closed
// polynomial are ignored; terms beyond MAX_TERMS are dropped but still close.
// A term is accepted on each transfer while s_ready is high.
// When the transfer closing the last open polynomial lands, s_ready drops. The
// block then issues one product per cycle, first_count * second_count products
// in all (at most MAX_TERMS*MAX_TERMS, none if either is empty), and FLUSH then
// inserts the last registered product. Each nonzero product is merged into a
// row of cells sorted by exponent.
// Result channel m_*: terms in ascending exponent order, m_last_out on the
// last; an empty result is one <0,0> term. Each emitted term shifts the row
// by one cell, so output runs at one term per cycle while m_ready is high.
// A stalled receiver holds the current term; s_ready returns the cycle after
// the last term's transfer. Reset empties the row and both polynomials.
module sparse_polynomial_multiply
    import spm_pkg::*;
#(
    parameter int unsigned MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic signed [TERM_W-1:0] s_term_coef,
    input  logic signed [TERM_W-1:0] s_term_exponent,
    input  logic                     s_final_term,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [COEF_W-1:0] m_product_coef,
    output logic signed [EXP_W-1:0]  m_product_exponent,
    output logic                     m_last_out
);

    localparam int unsigned DEPTH = MAX_TERMS * MAX_TERMS;
    localparam int unsigned IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);

    state_t state_reg, state_next;

    logic [TERM_W-1:0] a_coef [MAX_TERMS];
    logic [TERM_W-1:0] a_expo [MAX_TERMS];
    logic [TERM_W-1:0] b_coef [MAX_TERMS];
    logic [TERM_W-1:0] b_expo [MAX_TERMS];

    logic [CNT_W-1:0] a_cnt_reg, a_cnt_next;
    logic [CNT_W-1:0] b_cnt_reg, b_cnt_next;
    logic             a_closed_reg, a_closed_next;
    logic             b_closed_reg, b_closed_next;
    logic [IDX_W-1:0] ia_reg, ia_next;
    logic [IDX_W-1:0] ib_reg, ib_next;
    logic             pv_reg, pv_next;
    logic [COEF_W-1:0] pc_reg;
    logic [EXP_W-1:0]  pe_reg;
    logic signed [2*TERM_W-1:0] prod;

    logic  s_xfer, m_xfer, wr_a, wr_b, ia_last, ib_last;
    cmd_t  cmd;
    cell_t head;
    logic  head_last;

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_EMIT);
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid && m_ready;
    assign wr_a    = s_xfer && !s_operation && !a_closed_reg && (a_cnt_reg < CNT_W'(MAX_TERMS));
    assign wr_b    = s_xfer && s_operation && !b_closed_reg && (b_cnt_reg < CNT_W'(MAX_TERMS));
    assign ia_last = (CNT_W'(ia_reg) + CNT_W'(1)) == a_cnt_reg;
    assign ib_last = (CNT_W'(ib_reg) + CNT_W'(1)) == b_cnt_reg;
    assign prod    = $signed(a_coef[ia_reg]) * $signed(b_coef[ib_reg]);

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            a_coef[a_cnt_reg[IDX_W-1:0]] <= s_term_coef;
            a_expo[a_cnt_reg[IDX_W-1:0]] <= s_term_exponent;
        end
        if (wr_b) begin
            b_coef[b_cnt_reg[IDX_W-1:0]] <= s_term_coef;
            b_expo[b_cnt_reg[IDX_W-1:0]] <= s_term_exponent;
        end
    end

    always_comb begin
        state_next    = state_reg;
        a_cnt_next    = a_cnt_reg;
        b_cnt_next    = b_cnt_reg;
        a_closed_next = a_closed_reg;
        b_closed_next = b_closed_reg;
        ia_next       = ia_reg;
        ib_next       = ib_reg;
        pv_next       = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                ia_next = '0;
                ib_next = '0;
                if (wr_a) a_cnt_next = a_cnt_reg + CNT_W'(1);
                if (wr_b) b_cnt_next = b_cnt_reg + CNT_W'(1);
                if (s_xfer && s_final_term) begin
                    if (!s_operation) a_closed_next = 1'b1;
                    else              b_closed_next = 1'b1;
                end
                if (a_closed_next && b_closed_next) begin
                    if (a_cnt_next == '0 || b_cnt_next == '0) state_next = ST_FLUSH;
                    else                                     state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                pv_next = 1'b1;
                if (ib_last) begin
                    ib_next = '0;
                    if (ia_last) state_next = ST_FLUSH;
                    else         ia_next = ia_reg + IDX_W'(1);
                end else begin
                    ib_next = ib_reg + IDX_W'(1);
                end
            end
            ST_FLUSH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_xfer && m_last_out) begin
                    a_cnt_next    = '0;
                    b_cnt_next    = '0;
                    a_closed_next = 1'b0;
                    b_closed_next = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            a_cnt_reg    <= '0;
            b_cnt_reg    <= '0;
            a_closed_reg <= 1'b0;
            b_closed_reg <= 1'b0;
            ia_reg       <= '0;
            ib_reg       <= '0;
            pv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            a_cnt_reg    <= a_cnt_next;
            b_cnt_reg    <= b_cnt_next;
            a_closed_reg <= a_closed_next;
            b_closed_reg <= b_closed_next;
            ia_reg       <= ia_next;
            ib_reg       <= ib_next;
            pv_reg       <= pv_next;
        end
        pc_reg <= COEF_W'(prod);
        pe_reg <= EXP_W'($signed(a_expo[ia_reg])) + EXP_W'($signed(b_expo[ib_reg]));
    end

    assign cmd.ins   = pv_reg && (pc_reg != '0);
    assign cmd.shift = m_xfer;
    assign cmd.coef  = pc_reg;
    assign cmd.expo  = pe_reg;

    spm_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .head      (head),
        .head_last (head_last)
    );

    assign m_product_coef     = head.v ? $signed(head.coef) : '0;
    assign m_product_exponent = head.v ? $signed(head.expo) : '0;
    assign m_last_out         = head_last;

endmodule

### rtl/spm_cell.sv
// One table cell: holds a term, merges, inserts or shifts with its neighbors.
module spm_cell
    import spm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cmd_t  cmd,
    input  glob_t glob,
    input  cell_t prev_cell,
    input  logic  prev_lt,
    input  cell_t next_cell,
    output cell_t term_out,
    output logic  lt,
    output logic  eq,
    output logic  zsum
);

    cell_t             cell_reg;
    cell_t             cell_next;
    logic [COEF_W-1:0] sum;
    logic              ge;

    assign term_out = cell_reg;
    assign lt   = cell_reg.v && ($signed(cell_reg.expo) < $signed(cmd.expo));
    assign eq   = cell_reg.v && (cell_reg.expo == cmd.expo);
    assign ge   = cell_reg.v && !lt;
    assign sum  = cell_reg.coef + cmd.coef;
    assign zsum = cmd.ins && eq && (sum == '0);

    always_comb begin
        cell_next = cell_reg;
        if (cmd.shift) begin
            cell_next = next_cell;
        end else if (cmd.ins) begin
            if (glob.any_eq) begin
                if (glob.cancel) begin
                    if (ge) begin
                        cell_next = next_cell;
                    end
                end else if (eq) begin
                    cell_next.coef = sum;
                end
            end else if (!lt) begin
                if (prev_lt) begin
                    cell_next.v    = 1'b1;
                    cell_next.coef = cmd.coef;
                    cell_next.expo = cmd.expo;
                end else begin
                    cell_next = prev_cell;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.v <= 1'b0;
        end else begin
            cell_reg.v <= cell_next.v;
        end
        cell_reg.coef <= cell_next.coef;
        cell_reg.expo <= cell_next.expo;
    end

endmodule

### rtl/spm_chain.sv
// Row of table cells kept sorted by ascending exponent.
module spm_chain
    import spm_pkg::*;
#(
    parameter int unsigned DEPTH = MAX_TERMS_DEF * MAX_TERMS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  cmd_t  cmd,
    output cell_t head,
    output logic  head_last
);

    cell_t            cells [DEPTH];
    cell_t            nexts [DEPTH];
    cell_t            prevs [DEPTH];
    logic [DEPTH-1:0] lt;
    logic [DEPTH-1:0] prev_lt;
    logic [DEPTH-1:0] eq;
    logic [DEPTH-1:0] zsum;
    glob_t            glob;

    assign glob.any_eq = |eq;
    assign glob.cancel = |zsum;
    assign head        = cells[0];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign prevs[i]   = '0;
            assign prev_lt[i] = 1'b1;
        end else begin : g_mid
            assign prevs[i]   = cells[i-1];
            assign prev_lt[i] = lt[i-1];
        end
        if (i == DEPTH - 1) begin : g_end
            assign nexts[i] = '0;
        end else begin : g_inner
            assign nexts[i] = cells[i+1];
        end

        spm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .glob      (glob),
            .prev_cell (prevs[i]),
            .prev_lt   (prev_lt[i]),
            .next_cell (nexts[i]),
            .term_out  (cells[i]),
            .lt        (lt[i]),
            .eq        (eq[i]),
            .zsum      (zsum[i])
        );
    end

    assign head_last = !nexts[0].v;

endmodule

### rtl/spm_checker.sv
// Port-level checks for the sparse polynomial multiplier, bound to the top.
module spm_checker
    import spm_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [COEF_W-1:0] m_product_coef,
    input logic [EXP_W-1:0]  m_product_exponent,
    input logic              m_last_out
);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("load and emit active together");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_out |=> s_ready)
        else $error("no return to load after last term");

    a_zero_only_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_product_coef == '0 |-> m_last_out && m_product_exponent == '0)
        else $error("zero term emitted inside a result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_product_coef)
            && $stable(m_product_exponent))
        else $error("stalled result changed");

endmodule

bind sparse_polynomial_multiply spm_checker u_spm_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_product_coef     (m_product_coef),
    .m_product_exponent (m_product_exponent),
    .m_last_out         (m_last_out)
);

### dv/spm_checker.sv
// Checker for the sparse polynomial multiplier: predicts product terms and compares transfers.
`timescale 1ns / 1ps
module tb_spm_checker
    import spm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_operation,
    input  logic signed [TERM_W-1:0] s_term_coef,
    input  logic signed [TERM_W-1:0] s_term_exponent,
    input  logic                     s_final_term,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [COEF_W-1:0] m_product_coef,
    input  logic signed [EXP_W-1:0]  m_product_exponent,
    input  logic                     m_last_out,
    output int                       fail_count,
    output int                       terms_pending,
    output int                       products_seen
);

    localparam int NT = MAX_TERMS_DEF;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic signed [EXP_W-1:0]  expo;
        logic                     last;
    } prod_term_t;

    prod_term_t expected_terms[$];

    logic signed [TERM_W-1:0] a_coef[NT], a_exp[NT], b_coef[NT], b_exp[NT];
    int a_cnt, b_cnt;
    bit a_done, b_done;

    task automatic multiply_polys();
        logic signed [COEF_W-1:0] tc[$];
        logic signed [EXP_W-1:0]  te[$];
        logic signed [COEF_W-1:0] p;
        logic signed [EXP_W-1:0]  e;
        int k;
        prod_term_t t;
        for (int i = 0; i < a_cnt; i++) begin
            for (int j = 0; j < b_cnt; j++) begin
                p = COEF_W'(32'(a_coef[i]) * 32'(b_coef[j]));
                e = EXP_W'(a_exp[i]) + EXP_W'(b_exp[j]);
                if (p != 0) begin
                    k = 0;
                    while (k < tc.size() && te[k] < e) k++;
                    if (k < tc.size() && te[k] == e) begin
                        tc[k] = tc[k] + p;
                        if (tc[k] == 0) begin
                            tc.delete(k);
                            te.delete(k);
                        end
                    end else begin
                        tc.insert(k, p);
                        te.insert(k, e);
                    end
                end
            end
        end
        if (tc.size() == 0) begin
            t = '{coef: '0, expo: '0, last: 1'b1};
            expected_terms.push_back(t);
        end else begin
            for (int i = 0; i < tc.size(); i++) begin
                t = '{coef: tc[i], expo: te[i], last: (i == tc.size() - 1)};
                expected_terms.push_back(t);
            end
        end
        a_cnt = 0; b_cnt = 0; a_done = 0; b_done = 0;
    endtask

    always @(posedge aclk) begin
        prod_term_t x;
        if (!aresetn) begin
            a_cnt = 0; b_cnt = 0; a_done = 0; b_done = 0;
            fail_count <= 0; products_seen <= 0;
            expected_terms.delete();
            terms_pending = 0;
        end else begin
            if (m_valid && m_ready) begin
                products_seen <= products_seen + 1;
                if (expected_terms.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected product term coef=%0d exp=%0d last=%0b",
                                 m_product_coef, m_product_exponent, m_last_out);
                    fail_count <= fail_count + 1;
                end else begin
                    x = expected_terms.pop_front();
                    if (x.coef !== m_product_coef || x.expo !== m_product_exponent
                        || x.last !== m_last_out) begin
                        if (fail_count < 10)
                            $display("term mismatch exp: %0d,%0d,%0b act: %0d,%0d,%0b",
                                     x.coef, x.expo, x.last, m_product_coef,
                                     m_product_exponent, m_last_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (!s_operation && !a_done) begin
                    if (a_cnt < NT) begin
                        a_coef[a_cnt] = s_term_coef; a_exp[a_cnt] = s_term_exponent;
                        a_cnt = a_cnt + 1;
                    end
                    if (s_final_term) a_done = 1;
                end else if (s_operation && !b_done) begin
                    if (b_cnt < NT) begin
                        b_coef[b_cnt] = s_term_coef; b_exp[b_cnt] = s_term_exponent;
                        b_cnt = b_cnt + 1;
                    end
                    if (s_final_term) b_done = 1;
                end
                if (a_done && b_done) multiply_polys();
            end
            terms_pending = expected_terms.size();
        end
    end

endmodule

### dv/tb_sparse_polynomial_multiply.sv
// Testbench top for the sparse polynomial multiplier: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_sparse_polynomial_multiply;
    import spm_pkg::*;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, s_operation = 0, s_final_term = 0;
    logic signed [TERM_W-1:0] s_term_coef = 0, s_term_exponent = 0;
    logic m_valid, m_ready = 0, m_last_out;
    logic signed [COEF_W-1:0] m_product_coef;
    logic signed [EXP_W-1:0]  m_product_exponent;
    int fail_count, terms_pending, products_seen;
    int items_sent = 0, stall_pct = 16, idle_cycles = 0;
    bit timed_out = 0;
    bit drained = 0;

    always #6 aclk = ~aclk;

    sparse_polynomial_multiply dut (.*);

    tb_spm_checker chk (.*);

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready))) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("watchdog expired");
                $display("sparse_polynomial_multiply: mismatch");
                $finish;
            end
        end else idle_cycles <= 0;
    end

    task automatic send_term(input logic op, input logic signed [15:0] c,
                             input logic signed [15:0] e, input logic fin);
        while ($urandom_range(99) < stall_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_operation <= op; s_term_coef <= c;
        s_term_exponent <= e; s_final_term <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (terms_pending != 0) @(posedge aclk);
    endtask

    task automatic send_poly(input logic op, input int n, input bit extreme);
        logic signed [15:0] e;
        logic signed [15:0] c;
        e = extreme ? 16'(32'h8000 + $urandom_range(7))
                    : $signed(16'($urandom_range(40))) - 16'sd20;
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(3) == 0) ? 16'($urandom)
                                         : $signed(16'($urandom_range(6))) - 16'sd3;
            if (extreme && $urandom_range(1)) c = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
            send_term(op, c, e, i == n - 1);
            e = (i == n - 2 && extreme) ? 16'sh7fff
                                        : 16'(e + 1 + $urandom_range(extreme ? 9000 : 4));
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: extremes, cancellation, empty poly, ignored and overflow terms
        send_term(1'b0, 16'sh8000, 16'sh8000, 1'b0);
        send_term(1'b0, 16'sh7fff, 16'sh7fff, 1'b1);
        send_term(1'b0, 16'sh1234, 16'sd0, 1'b1);
        send_term(1'b1, 16'sh8000, 16'sh8000, 1'b0);
        send_term(1'b1, 16'sh7fff, 16'sh7fff, 1'b1);
        send_term(1'b0, 16'sd1, 16'sd0, 1'b0);
        send_term(1'b0, 16'sd1, 16'sd1, 1'b1);
        send_term(1'b1, 16'sd1, 16'sd1, 1'b0);
        send_term(1'b1, -16'sd1, 16'sd2, 1'b1);
        send_term(1'b0, 16'sd0, 16'sd5, 1'b1);
        send_term(1'b1, 16'sd0, 16'sd3, 1'b1);
        send_term(1'b0, 16'sd5, 16'sd2, 1'b1);
        send_term(1'b1, 16'sd0, 16'sd0, 1'b1);
        for (int i = 0; i < 9; i++) send_term(1'b0, 16'(i + 1), 16'(i), i == 8);
        send_term(1'b1, 16'sd3, -16'sd4, 1'b1);
        drain();
        repeat (80) @(posedge aclk);
        while (items_sent < 460) begin
            if (items_sent > 150 && items_sent < 260) stall_pct = 0;
            else stall_pct = 16;
            if ($urandom_range(9) == 0) send_term(1'($urandom_range(1)), 16'($urandom),
                                                  16'($urandom), 1'($urandom_range(1)));
            else begin
                send_poly(1'($urandom_range(1)), $urandom_range(1, 9), $urandom_range(5) == 0);
                send_poly(1'b1, $urandom_range(1, 8), $urandom_range(5) == 0);
                send_poly(1'b0, $urandom_range(1, 8), $urandom_range(5) == 0);
            end
            if (items_sent > 300 && !drained) begin
                drained = 1;
                drain();
            end
        end
        // close any open polynomial so every pending product arrives
        send_term(1'b0, 16'sd2, 16'sd0, 1'b1);
        send_term(1'b1, 16'sd3, 16'sd0, 1'b1);
        drain();
        repeat (100) @(posedge aclk);
        $display("sent %0d terms, checked %0d product terms", items_sent, products_seen);
        if (fail_count == 0 && terms_pending == 0)
            $display("sparse_polynomial_multiply: match");
        else
            $display("sparse_polynomial_multiply: mismatch");
        $finish;
    end
endmodule
